@@ design/thermistor_temp_block_stats_macros.svh @@
// Assertion macros for the thermistor temperature block
`ifndef THERMISTOR_TEMP_BLOCK_STATS_MACROS_SVH
`define THERMISTOR_TEMP_BLOCK_STATS_MACROS_SVH

// same-cycle implication
`define TBS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbs assertion failed");

// next-cycle implication
`define TBS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbs assertion failed");

`endif

@@ design/tbs_pkg.sv @@
// Types and constants shared by the thermistor temperature block
package tbs_pkg;

   localparam int COEF_W     = 48;
   localparam int DIVR_W     = 24;
   localparam int ADC_W      = 12;
   localparam int FS_W       = 16;
   localparam int TEMP_W     = 16;
   localparam int SUM_W      = 20;
   localparam int CSR_ADDR_W = 3;
   localparam int ACC_W      = 128;
   localparam int OPND_W     = 64;
   localparam int HALF_W     = 32;
   localparam int LOG_X_W    = 36;
   localparam int LOG_E_W    = 6;
   localparam int LOG_F_W    = 30;
   localparam int LOG_W      = LOG_E_W + LOG_F_W;
   localparam int QUO_W      = 63;

   localparam logic [27:0]        LN2_Q28       = 28'd186065279;
   localparam logic [QUO_W-1:0]   DIV_NUM       = 63'(100) << 56;
   localparam logic [DIVR_W-1:0]  DIVIDER_RESET = 24'd10000;
   localparam int                 KELVIN_OFFSET = 27315;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COEF_A  = 3'd0,
      CSR_COEF_B  = 3'd1,
      CSR_COEF_C  = 3'd2,
      CSR_COEF_D  = 3'd3,
      CSR_DIVIDER = 3'd4
   } csr_addr_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
      logic signed [COEF_W-1:0] coef_d;
      logic [DIVR_W-1:0]        divider_ohms;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [OPND_W-1:0] a;
      logic [OPND_W-1:0] b;
      logic              short_op;
      logic              neg;
      logic              keep;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] acc;
   } mul_rsp_type;

   typedef struct packed {
      logic                     valid;
      logic signed [TEMP_W-1:0] temp;
      logic                     fault;
   } conv_res_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] sample_temp;
      logic                     range_fault;
      logic                     block_done;
      logic signed [TEMP_W-1:0] min_temp;
      logic signed [TEMP_W-1:0] max_temp;
      logic signed [TEMP_W-1:0] avg_temp;
   } stats_res_type;

   typedef enum logic [3:0] {
      CV_IDLE, CV_MUL_GO, CV_MUL_WAIT, CV_NORM, CV_LOG_END,
      CV_FIN, CV_DIV, CV_TEMP, CV_DONE
   } conv_state_type;

   typedef enum logic [3:0] {
      OP_NUM, OP_SQ, OP_LN, OP_L2, OP_L3, OP_SA, OP_SB, OP_SC, OP_SD
   } mul_op_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_DIV, ST_RES
   } stats_state_type;

endpackage

@@ design/tbs_mul.sv @@
// Shared multiply-accumulate unit: 32x32 multiplier over up to four partial products
module tbs_mul import tbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [OPND_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic                short_ff, short_in, neg_ff, neg_in;
   logic                busy_ff, busy_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [1:0]          sel_ff, sel_in;
   logic                pp_vld_ff, pp_vld_in;
   logic [2*HALF_W-1:0] pp_ff, pp_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                done_ff, done_in;
   logic [2:0]          npp;
   logic [HALF_W-1:0]   opa, opb;
   logic [ACC_W-1:0]    pp_shift;

   always_comb begin
      npp = short_ff ? 3'd1 : 3'd4;
      // partial product order: a0b0, a0b1, a1b0, a1b1
      opa = cnt_ff[1] ? a_ff[OPND_W-1:HALF_W] : a_ff[HALF_W-1:0];
      opb = cnt_ff[0] ? b_ff[OPND_W-1:HALF_W] : b_ff[HALF_W-1:0];
      case (sel_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1:    pp_shift = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_shift = {32'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff, 64'd0};
      endcase
   end

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      short_in  = short_ff;
      neg_in    = neg_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      sel_in    = sel_ff;
      pp_vld_in = pp_vld_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      if (req.start) begin
         a_in      = req.a;
         b_in      = req.b;
         short_in  = req.short_op;
         neg_in    = req.neg;
         busy_in   = 1'b1;
         cnt_in    = 3'd0;
         pp_vld_in = 1'b0;
         if (!req.keep) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         if (cnt_ff < npp) begin
            pp_in     = 64'(opa) * 64'(opb);
            sel_in    = cnt_ff[1:0];
            pp_vld_in = 1'b1;
            cnt_in    = cnt_ff + 3'd1;
         end else begin
            pp_vld_in = 1'b0;
         end
         if (pp_vld_ff) begin
            acc_in = neg_ff ? (acc_ff - pp_shift) : (acc_ff + pp_shift);
         end
         if (cnt_ff == npp && pp_vld_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         cnt_ff    <= 3'd0;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         cnt_ff    <= cnt_in;
         pp_vld_ff <= pp_vld_in;
         done_ff   <= done_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      short_ff <= short_in;
      neg_ff   <= neg_in;
      sel_ff   <= sel_in;
      pp_ff    <= pp_in;
      acc_ff   <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.acc  = acc_ff;

endmodule

@@ design/tbs_conv.sv @@
// Conversion sequencer: log2 by squaring, Steinhart-Hart sum, reciprocal by restoring divide
module tbs_conv import tbs_pkg::*; #(
   parameter int ADC_FULL_SCALE = 4095
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ADC_W-1:0] adc_sample,
   input  cfg_type          cfg,
   output mul_req_type      mul_req,
   input  mul_rsp_type      mul_rsp,
   output conv_res_type     res
);

   localparam logic [FS_W-1:0] FS = FS_W'(ADC_FULL_SCALE);

   conv_state_type state_ff, state_in;
   mul_op_type     op_ff, op_in;

   logic [ADC_W-1:0]         adc_ff, adc_in;
   logic                     fault_ff, fault_in;
   logic                     side_ff, side_in;
   logic [LOG_X_W-1:0]       x_ff, x_in;
   logic [LOG_E_W-1:0]       e_ff, e_in;
   logic [HALF_W-1:0]        m_ff, m_in;
   logic [LOG_F_W-1:0]       frac_ff, frac_in;
   logic [4:0]               iter_ff, iter_in;
   logic [LOG_W-1:0]         lnum_ff, lnum_in;
   logic                     lneg_ff, lneg_in;
   logic [LOG_W-1:0]         lrmag_ff, lrmag_in;
   logic [HALF_W-1:0]        lm_ff, lm_in;
   logic [39:0]              l2m_ff, l2m_in, l3m_ff, l3m_in;
   logic                     sneg_ff, sneg_in;
   logic [OPND_W-1:0]        mag_ff, mag_in;
   logic [OPND_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]         q_ff, q_in;
   logic [5:0]               dcnt_ff, dcnt_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;

   logic                     fault_now;
   logic [DIVR_W-1:0]        r1;
   logic [FS_W-1:0]          den;
   logic [LOG_W-1:0]         log_val;
   logic [LOG_W:0]           lr, lr_neg;
   logic [LOG_W-1:0]         lr_mag;
   logic                     sq_bit;
   logic [HALF_W-1:0]        sq_m;
   logic [ACC_W-1:0]         sh, smag;
   logic [OPND_W:0]          rem_sh;
   logic                     q_bit;
   logic signed [QUO_W+1:0]  tq, tk, tt;

   function automatic logic [OPND_W-1:0] mag48(input logic [COEF_W-1:0] v);
      logic [COEF_W-1:0] n;
      n = v[COEF_W-1] ? (~v + 48'd1) : v;
      return {16'd0, n};
   endfunction

   always_comb begin
      fault_now = (adc_sample == '0) || ({4'd0, adc_sample} >= FS);
      r1        = (cfg.divider_ohms == '0) ? 24'd1 : cfg.divider_ohms;
      den       = FS - {4'd0, adc_ff};
      log_val   = {e_ff, frac_ff};
      lr        = {1'b0, lnum_ff} - {1'b0, log_val};
      lr_neg    = ~lr + 37'd1;
      lr_mag    = lr[LOG_W] ? lr_neg[LOG_W-1:0] : lr[LOG_W-1:0];
      // m*m >> 31, renormalized when it reached 2.0
      sq_bit    = mul_rsp.acc[63];
      sq_m      = sq_bit ? mul_rsp.acc[63:32] : mul_rsp.acc[62:31];
      sh        = {{20{mul_rsp.acc[ACC_W-1]}}, mul_rsp.acc[ACC_W-1:20]};
      smag      = mul_rsp.acc[ACC_W-1] ? (~sh + 128'd1) : sh;
      rem_sh    = {rem_ff, DIV_NUM[dcnt_ff]};
      q_bit     = rem_sh >= {1'b0, mag_ff};
      tq        = $signed({2'b00, q_ff});
      tk        = sneg_ff ? -tq : tq;
      tt        = tk - 65'(KELVIN_OFFSET);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CV_IDLE: begin
            if (start) begin
               state_in = fault_now ? CV_DONE : CV_MUL_GO;
            end
         end
         CV_MUL_GO: state_in = CV_MUL_WAIT;
         CV_MUL_WAIT: begin
            if (mul_rsp.done) begin
               case (op_ff)
                  OP_NUM:  state_in = CV_NORM;
                  OP_SQ:   state_in = (iter_ff == 5'(LOG_F_W-1)) ? CV_LOG_END : CV_MUL_GO;
                  OP_SD:   state_in = CV_FIN;
                  default: state_in = CV_MUL_GO;
               endcase
            end
         end
         CV_NORM:    state_in = x_ff[LOG_X_W-1] ? CV_MUL_GO : CV_NORM;
         CV_LOG_END: state_in = side_ff ? CV_MUL_GO : CV_NORM;
         CV_FIN: begin
            if (smag == '0) begin
               state_in = CV_DONE;
            end else if (|smag[ACC_W-1:OPND_W]) begin
               state_in = CV_TEMP;
            end else begin
               state_in = CV_DIV;
            end
         end
         CV_DIV:  state_in = (dcnt_ff == 6'd0) ? CV_TEMP : CV_DIV;
         CV_TEMP: state_in = CV_DONE;
         CV_DONE: state_in = CV_IDLE;
         default: state_in = CV_IDLE;
      endcase
   end

   // outputs: multiplier operands per operation
   always_comb begin
      mul_req.start    = (state_ff == CV_MUL_GO);
      mul_req.a        = '0;
      mul_req.b        = '0;
      mul_req.short_op = 1'b0;
      mul_req.neg      = 1'b0;
      mul_req.keep     = 1'b0;
      case (op_ff)
         OP_NUM: begin
            mul_req.a        = 64'(adc_ff);
            mul_req.b        = 64'(r1);
            mul_req.short_op = 1'b1;
         end
         OP_SQ: begin
            mul_req.a        = 64'(m_ff);
            mul_req.b        = 64'(m_ff);
            mul_req.short_op = 1'b1;
         end
         OP_LN: begin
            mul_req.a = 64'(lrmag_ff);
            mul_req.b = 64'(LN2_Q28);
         end
         OP_L2: begin
            mul_req.a        = 64'(lm_ff);
            mul_req.b        = 64'(lm_ff);
            mul_req.short_op = 1'b1;
         end
         OP_L3: begin
            mul_req.a = 64'(lm_ff);
            mul_req.b = 64'(l2m_ff);
         end
         OP_SA: begin
            mul_req.a   = mag48(cfg.coef_a);
            mul_req.b   = 64'd1 << 24;
            mul_req.neg = cfg.coef_a[COEF_W-1];
         end
         OP_SB: begin
            mul_req.a    = mag48(cfg.coef_b);
            mul_req.b    = 64'(lm_ff);
            mul_req.neg  = cfg.coef_b[COEF_W-1] ^ lneg_ff;
            mul_req.keep = 1'b1;
         end
         OP_SC: begin
            mul_req.a    = mag48(cfg.coef_c);
            mul_req.b    = 64'(l2m_ff);
            mul_req.neg  = cfg.coef_c[COEF_W-1];
            mul_req.keep = 1'b1;
         end
         OP_SD: begin
            mul_req.a    = mag48(cfg.coef_d);
            mul_req.b    = 64'(l3m_ff);
            mul_req.neg  = cfg.coef_d[COEF_W-1] ^ lneg_ff;
            mul_req.keep = 1'b1;
         end
         default: begin
            mul_req.a = '0;
         end
      endcase
      res.valid = (state_ff == CV_DONE);
      res.temp  = temp_ff;
      res.fault = fault_ff;
   end

   // datapath
   always_comb begin
      op_in    = op_ff;
      adc_in   = adc_ff;
      fault_in = fault_ff;
      side_in  = side_ff;
      x_in     = x_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      iter_in  = iter_ff;
      lnum_in  = lnum_ff;
      lneg_in  = lneg_ff;
      lrmag_in = lrmag_ff;
      lm_in    = lm_ff;
      l2m_in   = l2m_ff;
      l3m_in   = l3m_ff;
      sneg_in  = sneg_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      dcnt_in  = dcnt_ff;
      temp_in  = temp_ff;
      case (state_ff)
         CV_IDLE: begin
            if (start) begin
               adc_in   = adc_sample;
               fault_in = fault_now;
               temp_in  = '0;
               side_in  = 1'b0;
               op_in    = OP_NUM;
            end
         end
         CV_MUL_WAIT: begin
            if (mul_rsp.done) begin
               case (op_ff)
                  OP_NUM: begin
                     x_in = (mul_rsp.acc[LOG_X_W-1:0] == '0) ? 36'd1
                                                            : mul_rsp.acc[LOG_X_W-1:0];
                     e_in = LOG_E_W'(LOG_X_W-1);
                  end
                  OP_SQ: begin
                     m_in    = sq_m;
                     frac_in = {frac_ff[LOG_F_W-2:0], sq_bit};
                     iter_in = iter_ff + 5'd1;
                  end
                  OP_LN: begin
                     lm_in = mul_rsp.acc[65:34];
                     op_in = OP_L2;
                  end
                  OP_L2: begin
                     l2m_in = mul_rsp.acc[63:24];
                     op_in  = OP_L3;
                  end
                  OP_L3: begin
                     l3m_in = mul_rsp.acc[63:24];
                     op_in  = OP_SA;
                  end
                  OP_SA:   op_in = OP_SB;
                  OP_SB:   op_in = OP_SC;
                  OP_SC:   op_in = OP_SD;
                  default: op_in = op_ff;
               endcase
            end
         end
         CV_NORM: begin
            // one bit a cycle until the top bit lands in bit 35
            if (x_ff[LOG_X_W-1]) begin
               m_in    = x_ff[LOG_X_W-1:LOG_X_W-HALF_W];
               frac_in = '0;
               iter_in = '0;
               op_in   = OP_SQ;
            end else begin
               x_in = {x_ff[LOG_X_W-2:0], 1'b0};
               e_in = e_ff - 6'd1;
            end
         end
         CV_LOG_END: begin
            if (!side_ff) begin
               lnum_in = log_val;
               x_in    = (den == '0) ? 36'd1 : {20'd0, den};
               e_in    = LOG_E_W'(LOG_X_W-1);
               side_in = 1'b1;
            end else begin
               lneg_in  = lr[LOG_W];
               lrmag_in = lr_mag;
               op_in    = OP_LN;
            end
         end
         CV_FIN: begin
            sneg_in = mul_rsp.acc[ACC_W-1];
            mag_in  = smag[OPND_W-1:0];
            rem_in  = '0;
            q_in    = '0;
            dcnt_in = 6'(QUO_W-1);
            if (smag == '0) begin
               temp_in = 16'sh7FFF;
            end
         end
         CV_DIV: begin
            rem_in  = q_bit ? 64'(rem_sh - {1'b0, mag_ff}) : rem_sh[OPND_W-1:0];
            q_in    = {q_ff[QUO_W-2:0], q_bit};
            dcnt_in = dcnt_ff - 6'd1;
         end
         CV_TEMP: begin
            if (tt > 65'sd32767) begin
               temp_in = 16'sh7FFF;
            end else if (tt < -65'sd32768) begin
               temp_in = 16'sh8000;
            end else begin
               temp_in = tt[TEMP_W-1:0];
            end
         end
         default: begin
            temp_in = temp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
         op_ff    <= OP_NUM;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
      adc_ff   <= adc_in;
      fault_ff <= fault_in;
      side_ff  <= side_in;
      x_ff     <= x_in;
      e_ff     <= e_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      iter_ff  <= iter_in;
      lnum_ff  <= lnum_in;
      lneg_ff  <= lneg_in;
      lrmag_ff <= lrmag_in;
      lm_ff    <= lm_in;
      l2m_ff   <= l2m_in;
      l3m_ff   <= l3m_in;
      sneg_ff  <= sneg_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      dcnt_ff  <= dcnt_in;
      temp_ff  <= temp_in;
   end

endmodule

@@ design/tbs_stats.sv @@
// Block statistics: running min/max/sum and held results with a reciprocal average divide
module tbs_stats import tbs_pkg::*; #(
   parameter int WINDOW_LEN = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  conv_res_type  cin,
   input  logic          ack,
   output logic          res_valid,
   output stats_res_type res
);

   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam logic [CNT_W-1:0] WIN = CNT_W'(WINDOW_LEN);
   // |sum| / WINDOW_LEN = (|sum| * RCP) >> DIV_SH, exact for any 20-bit magnitude
   localparam int DIV_SH = SUM_W + $clog2(WINDOW_LEN);
   localparam int RCP_W  = DIV_SH + 1;
   localparam int PRD_W  = SUM_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((longint'(1) << DIV_SH) + longint'(WINDOW_LEN - 1)) / longint'(WINDOW_LEN));

   stats_state_type state_ff, state_in;

   logic [CNT_W-1:0]         cnt_ff, cnt_in, cnt_next;
   logic signed [TEMP_W-1:0] rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic signed [SUM_W-1:0]  rsum_ff, rsum_in;
   logic signed [TEMP_W-1:0] hmin_ff, hmin_in, hmax_ff, hmax_in, havg_ff, havg_in;
   logic signed [TEMP_W-1:0] t_ff, t_in;
   logic                     fault_ff, fault_in, done_ff, done_in;
   logic [SUM_W-1:0]         dvd_ff, dvd_in;
   logic                     sneg_ff, sneg_in;

   logic signed [TEMP_W-1:0] nmin, nmax;
   logic signed [SUM_W-1:0]  nsum;
   logic                     blk_end;
   logic [PRD_W-1:0]         prod;
   logic [SUM_W-1:0]         q_fin, q_neg;

   always_comb begin
      if (cnt_ff == '0) begin
         nmin = cin.temp;
         nmax = cin.temp;
         nsum = SUM_W'(cin.temp);
      end else begin
         nmin = (cin.temp < rmin_ff) ? cin.temp : rmin_ff;
         nmax = (cin.temp > rmax_ff) ? cin.temp : rmax_ff;
         nsum = rsum_ff + SUM_W'(cin.temp);
      end
      cnt_next = cnt_ff + 1'b1;
      blk_end  = cnt_next >= WIN;
      prod     = PRD_W'(dvd_ff) * PRD_W'(RCP);
      q_fin    = prod[DIV_SH +: SUM_W];
      q_neg    = ~q_fin + 20'd1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cin.valid) begin
               state_in = blk_end ? ST_DIV : ST_RES;
            end
         end
         ST_DIV:  state_in = ST_RES;
         ST_RES:  state_in = ack ? ST_IDLE : ST_RES;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      res_valid       = (state_ff == ST_RES);
      res.sample_temp = t_ff;
      res.range_fault = fault_ff;
      res.block_done  = done_ff;
      res.min_temp    = hmin_ff;
      res.max_temp    = hmax_ff;
      res.avg_temp    = havg_ff;
   end

   // datapath
   always_comb begin
      cnt_in   = cnt_ff;
      rmin_in  = rmin_ff;
      rmax_in  = rmax_ff;
      rsum_in  = rsum_ff;
      hmin_in  = hmin_ff;
      hmax_in  = hmax_ff;
      havg_in  = havg_ff;
      t_in     = t_ff;
      fault_in = fault_ff;
      done_in  = done_ff;
      dvd_in   = dvd_ff;
      sneg_in  = sneg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cin.valid) begin
               rmin_in  = nmin;
               rmax_in  = nmax;
               rsum_in  = nsum;
               t_in     = cin.temp;
               fault_in = cin.fault;
               done_in  = blk_end;
               if (blk_end) begin
                  hmin_in = nmin;
                  hmax_in = nmax;
                  cnt_in  = '0;
                  sneg_in = nsum[SUM_W-1];
                  dvd_in  = nsum[SUM_W-1] ? (~nsum + 20'd1) : nsum;
               end else begin
                  cnt_in = cnt_next;
               end
            end
         end
         ST_DIV: begin
            // magnitude divided, sign put back: truncation toward zero
            havg_in = sneg_ff ? q_neg[TEMP_W-1:0] : q_fin[TEMP_W-1:0];
         end
         default: begin
            t_in = t_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rmin_ff  <= '0;
         rmax_ff  <= '0;
         rsum_ff  <= '0;
         hmin_ff  <= '0;
         hmax_ff  <= '0;
         havg_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rmin_ff  <= rmin_in;
         rmax_ff  <= rmax_in;
         rsum_ff  <= rsum_in;
         hmin_ff  <= hmin_in;
         hmax_ff  <= hmax_in;
         havg_ff  <= havg_in;
      end
      t_ff     <= t_in;
      fault_ff <= fault_in;
      done_ff  <= done_in;
      dvd_ff   <= dvd_in;
      sneg_ff  <= sneg_in;
   end

endmodule

@@ design/thermistor_temp_block_stats.sv @@
// Thermistor temperature converter with block statistics, top level.
// One sample is taken at a time. A normal sample goes from acceptance to the output
// register through two base-2 logarithms, each a one-bit-a-cycle normalize plus 30
// squarings on the shared 32x32 multiply-accumulate unit, then seven more products,
// and a 63-step restoring divide for the reciprocal. A zero or very large
// Steinhart-Hart sum skips the divide. A sample that ends a block passes through an
// extra state for the average. A sample of 0 or at or above full scale skips the
// conversion. req_ready stays low from acceptance until the item is loaded into the
// output register; the result then waits there for rsp_ready while the next sample
// is accepted.
module thermistor_temp_block_stats import tbs_pkg::*; #(
   parameter int WINDOW_LEN     = 10,
   parameter int ADC_FULL_SCALE = 4095
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ADC_W-1:0]         req_adc_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [TEMP_W-1:0] rsp_sample_temp,
   output logic                     rsp_range_fault,
   output logic                     rsp_block_done,
   output logic signed [TEMP_W-1:0] rsp_min_temp,
   output logic signed [TEMP_W-1:0] rsp_max_temp,
   output logic signed [TEMP_W-1:0] rsp_avg_temp,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_W-1:0]    csr_addr,
   input  logic [COEF_W-1:0]        csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          busy_ff, busy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   stats_res_type out_ff, out_in;

   mul_req_type   mul_req;
   mul_rsp_type   mul_rsp;
   conv_res_type  conv_res;
   stats_res_type stats_res;
   logic          stats_valid;
   logic          accept, load;

   assign accept = req_valid && req_ready;
   assign load   = stats_valid && (!rsp_valid_ff || rsp_ready);

   tbs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   tbs_conv #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_conv (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .adc_sample (req_adc_sample),
      .cfg        (cfg_ff),
      .mul_req    (mul_req),
      .mul_rsp    (mul_rsp),
      .res        (conv_res)
   );

   tbs_stats #(.WINDOW_LEN(WINDOW_LEN)) u_stats (
      .clock     (clock),
      .reset     (reset),
      .cin       (conv_res),
      .ack       (load),
      .res_valid (stats_valid),
      .res       (stats_res)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_COEF_A:  cfg_in.coef_a       = csr_wdata;
            CSR_COEF_B:  cfg_in.coef_b       = csr_wdata;
            CSR_COEF_C:  cfg_in.coef_c       = csr_wdata;
            CSR_COEF_D:  cfg_in.coef_d       = csr_wdata;
            CSR_DIVIDER: cfg_in.divider_ohms = csr_wdata[DIVR_W-1:0];
            default:     cfg_in              = cfg_ff;
         endcase
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (load) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         out_in       = stats_res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a       <= '0;
         cfg_ff.coef_b       <= '0;
         cfg_ff.coef_c       <= '0;
         cfg_ff.coef_d       <= '0;
         cfg_ff.divider_ohms <= DIVIDER_RESET;
         busy_ff             <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
   end

   assign req_ready       = !busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_temp = out_ff.sample_temp;
   assign rsp_range_fault = out_ff.range_fault;
   assign rsp_block_done  = out_ff.block_done;
   assign rsp_min_temp    = out_ff.min_temp;
   assign rsp_max_temp    = out_ff.max_temp;
   assign rsp_avg_temp    = out_ff.avg_temp;

endmodule

@@ design/tbs_checker.sv @@
// Port-level checker for the thermistor temperature block, with its bind
`include "thermistor_temp_block_stats_macros.svh"

module tbs_checker import tbs_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [ADC_W-1:0]         req_adc_sample,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] rsp_sample_temp,
   input logic                     rsp_range_fault,
   input logic                     rsp_block_done,
   input logic signed [TEMP_W-1:0] rsp_min_temp,
   input logic signed [TEMP_W-1:0] rsp_max_temp,
   input logic signed [TEMP_W-1:0] rsp_avg_temp,
   input logic                     csr_we,
   input logic [CSR_ADDR_W-1:0]    csr_addr,
   input logic [COEF_W-1:0]        csr_wdata
);

   // one item in flight: no new sample right after one is taken
   `TBS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   `TBS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_temp) && $stable(rsp_avg_temp) && $stable(rsp_block_done))

   `TBS_ASSERT_IMP(a_fault_zero, clock, reset, rsp_valid && rsp_range_fault, rsp_sample_temp == 16'sd0)

   // held average lies between held minimum and maximum
   `TBS_ASSERT_IMP(a_held_order, clock, reset, rsp_valid, (rsp_min_temp <= rsp_max_temp) && (rsp_avg_temp >= rsp_min_temp) && (rsp_avg_temp <= rsp_max_temp))

endmodule

bind thermistor_temp_block_stats tbs_checker u_tbs_checker (.*);

@@ tb/tb_thermistor_temp_block_stats.sv @@
// Testbench for the thermistor temperature block: random stimulus checked against a local model
`timescale 1ns / 100ps

module tb_thermistor_temp_block_stats;
   import tbs_pkg::*;

   localparam int WINDOW     = 10;
   localparam int FULL_SCALE = 4095;
   localparam int LONG_HOLD  = 1500;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [ADC_W-1:0]         req_adc_sample;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [TEMP_W-1:0] rsp_sample_temp;
   logic                     rsp_range_fault;
   logic                     rsp_block_done;
   logic signed [TEMP_W-1:0] rsp_min_temp;
   logic signed [TEMP_W-1:0] rsp_max_temp;
   logic signed [TEMP_W-1:0] rsp_avg_temp;
   logic                     csr_we;
   logic [CSR_ADDR_W-1:0]    csr_addr;
   logic [COEF_W-1:0]        csr_wdata;

   thermistor_temp_block_stats #(
      .WINDOW_LEN(WINDOW),
      .ADC_FULL_SCALE(FULL_SCALE)
   ) dut (.*);

   // local copy of the block's configuration and statistics state
   logic signed [COEF_W-1:0] m_coef_a, m_coef_b, m_coef_c, m_coef_d;
   logic [DIVR_W-1:0]        m_divider;
   int                       m_count;
   int                       m_run_min, m_run_max, m_run_sum;
   int                       m_held_min, m_held_max, m_held_avg;

   logic [ADC_W-1:0] sample_queue[$];
   stats_res_type    results_due[$];
   int               errors;
   int               accepted;
   int               hold_left;
   bit               hold_done;
   bit               req_fire;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [63:0] log2_fix(logic [63:0] x);
      int          e;
      logic [63:0] m, frac;
      if (x == 0) x = 1;
      e = 0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
      frac = 0;
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 64'd1;
            m = m >> 1;
         end
      end
      return (64'(e) << 30) | frac;
   endfunction

   function automatic int sample_to_centi(logic [ADC_W-1:0] adc);
      logic [63:0]         r1, lmag, l2m, l3m, q;
      logic signed [63:0]  lr, lval, l3val, t;
      logic signed [127:0] ca, cb, cc, cd, acc, sh, magn;
      logic                neg;
      r1 = (m_divider == 0) ? 64'd1 : 64'(m_divider);
      lr = $signed(log2_fix(64'(adc) * r1)) - $signed(log2_fix(64'(FULL_SCALE - adc)));
      lmag = ((lr < 0) ? -lr : lr);
      lmag = (lmag * 64'(LN2_Q28)) >> 34;
      lval = (lr < 0) ? -$signed(lmag) : $signed(lmag);
      l2m = (lmag * lmag) >> 24;
      l3m = (lmag * l2m) >> 24;
      l3val = (lval < 0) ? -$signed(l3m) : $signed(l3m);
      ca = m_coef_a;
      cb = m_coef_b;
      cc = m_coef_c;
      cd = m_coef_d;
      acc = ca * (128'sd1 <<< 24) + cb * 128'(lval) + cc * $signed(128'(l2m))
            + cd * 128'(l3val);
      sh = acc >>> 20;
      neg = sh[127];
      magn = neg ? -sh : sh;
      if (magn == 0) return 32767;
      q = (magn[127:64] != 0) ? 64'd0 : 64'(DIV_NUM) / magn[63:0];
      t = (neg ? -$signed(q) : $signed(q)) - KELVIN_OFFSET;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return int'(t);
   endfunction

   function automatic stats_res_type track_sample(logic [ADC_W-1:0] adc);
      stats_res_type r;
      bit            fault;
      int            t;
      fault = (adc == 0) || (adc >= FULL_SCALE);
      t = fault ? 0 : sample_to_centi(adc);
      r.block_done = 1'b0;
      if (m_count == 0) begin
         m_run_min = t;
         m_run_max = t;
         m_run_sum = t;
      end else begin
         if (t < m_run_min) m_run_min = t;
         if (t > m_run_max) m_run_max = t;
         m_run_sum += t;
      end
      m_count++;
      if (m_count >= WINDOW) begin
         m_held_min = m_run_min;
         m_held_max = m_run_max;
         m_held_avg = m_run_sum / WINDOW;
         m_count = 0;
         r.block_done = 1'b1;
      end
      r.sample_temp = TEMP_W'(t);
      r.range_fault = fault;
      r.min_temp = TEMP_W'(m_held_min);
      r.max_temp = TEMP_W'(m_held_max);
      r.avg_temp = TEMP_W'(m_held_avg);
      return r;
   endfunction

   // sender: one item at a time, held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_adc_sample <= '0;
      end else if (!req_valid || req_fire) begin
         if (sample_queue.size() > 0 &&
             ((accepted > 300 && accepted < 420) || $urandom_range(99) >= 13)) begin
            req_valid <= 1'b1;
            req_adc_sample <= sample_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted == 500) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (accepted > 300 && accepted < 420) || $urandom_range(99) >= 13;
      end
   end

   always @(posedge clock) begin
      stats_res_type due;
      req_fire <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         results_due.push_back(track_sample(req_adc_sample));
         accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: result with no item pending, temp %0d", $time, rsp_sample_temp);
            errors++;
         end else begin
            due = results_due.pop_front();
            if (rsp_sample_temp !== due.sample_temp) begin
               $display("%0t: sample_temp exp %0d got %0d", $time, due.sample_temp,
                        rsp_sample_temp);
               errors++;
            end
            if (rsp_range_fault !== due.range_fault) begin
               $display("%0t: range_fault exp %0b got %0b", $time, due.range_fault,
                        rsp_range_fault);
               errors++;
            end
            if (rsp_block_done !== due.block_done) begin
               $display("%0t: block_done exp %0b got %0b", $time, due.block_done,
                        rsp_block_done);
               errors++;
            end
            if (rsp_min_temp !== due.min_temp) begin
               $display("%0t: min_temp exp %0d got %0d", $time, due.min_temp, rsp_min_temp);
               errors++;
            end
            if (rsp_max_temp !== due.max_temp) begin
               $display("%0t: max_temp exp %0d got %0d", $time, due.max_temp, rsp_max_temp);
               errors++;
            end
            if (rsp_avg_temp !== due.avg_temp) begin
               $display("%0t: avg_temp exp %0d got %0d", $time, due.avg_temp, rsp_avg_temp);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [COEF_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_COEF_A:  m_coef_a = val;
         CSR_COEF_B:  m_coef_b = val;
         CSR_COEF_C:  m_coef_c = val;
         CSR_COEF_D:  m_coef_d = val;
         CSR_DIVIDER: m_divider = val[DIVR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_coefs(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                            logic [COEF_W-1:0] c, logic [COEF_W-1:0] d);
      write_reg(CSR_COEF_A, a);
      write_reg(CSR_COEF_B, b);
      write_reg(CSR_COEF_C, c);
      write_reg(CSR_COEF_D, d);
   endtask

   task automatic drain();
      while (sample_queue.size() > 0 || req_valid || results_due.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_random(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 5)
            sample_queue.push_back((pick < 2) ? 12'd0 : 12'd4095);
         else if (pick < 25)
            sample_queue.push_back(ADC_W'($urandom));
         else
            sample_queue.push_back(ADC_W'($urandom_range(4094, 1)));
      end
      drain();
   endtask

   // typical NTC fit, scaled by 2^52
   localparam logic [COEF_W-1:0] TYP_A = 48'd5084733437952;
   localparam logic [COEF_W-1:0] TYP_B = 48'd1054301298688;
   localparam logic [COEF_W-1:0] TYP_D = 48'd395181056;
   localparam logic [COEF_W-1:0] C_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [COEF_W-1:0] C_MIN = 48'h8000_0000_0000;

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_adc_sample = '0;
      rsp_ready = 1'b0;
      errors = 0;
      accepted = 0;
      m_coef_a = 0;
      m_coef_b = 0;
      m_coef_c = 0;
      m_coef_d = 0;
      m_divider = DIVIDER_RESET;
      m_count = 0;
      m_run_min = 0;
      m_run_max = 0;
      m_run_sum = 0;
      m_held_min = 0;
      m_held_max = 0;
      m_held_avg = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset coefficients: all zero, so every good sample hits the zero-sum case
      sample_queue = '{12'd0, 12'd1, 12'd4094, 12'd4095, 12'd2048};
      drain();

      set_coefs(TYP_A, TYP_B, 48'd0, TYP_D);
      sample_queue = '{12'd1, 12'd4094, 12'd0, 12'd4095, 12'd2047, 12'd2048, 12'd1024,
                       12'd3072, 12'd100, 12'd4000, 12'd2, 12'd4093, 12'hAAA, 12'h555,
                       12'd0, 12'd0, 12'd4095};
      drain();
      queue_random(300);

      // unknown register indexes must not disturb anything
      write_reg(3'd5, C_MAX);
      write_reg(3'd6, C_MIN);
      write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_DIVIDER, 48'd1);
      queue_random(80);
      write_reg(CSR_DIVIDER, 48'hFFFF_FF_FFFFFF);
      queue_random(80);
      write_reg(CSR_DIVIDER, 48'd0);          // treated as one ohm
      queue_random(50);

      write_reg(CSR_DIVIDER, 48'd10000);
      set_coefs(C_MAX, C_MAX, C_MAX, C_MAX);
      queue_random(50);
      set_coefs(C_MIN, C_MIN, C_MIN, C_MIN);
      queue_random(50);
      set_coefs(48'd0, 48'd0, 48'd0, 48'd0);
      queue_random(30);

      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_DIVIDER, 48'($urandom));
         set_coefs(COEF_W'({$urandom, $urandom}),
                   COEF_W'({$urandom, $urandom} >>> $urandom_range(20)),
                   COEF_W'({$urandom, $urandom} >>> $urandom_range(30)),
                   COEF_W'({$urandom, $urandom} >>> $urandom_range(40)));
         queue_random(50);
      end

      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
